// ===== hdl/ffa_pkg.sv =====
package ffa_pkg;

  localparam int unsigned CntW = 11;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] size;
  } in_item_t;

  typedef struct packed {
    logic [31:0]     result_addr;
    logic            status;
    logic [31:0]     total_free;
    logic [CntW-1:0] entry_count;
    logic [CntW-1:0] peak_entries;
    logic [31:0]     lost_count;
    logic [31:0]     lost_size;
  } out_item_t;

  // One table entry.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } region_t;

endpackage

// ===== hdl/ffa_table.sv =====
// Region table: one write port, one registered read port.
module ffa_table import ffa_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  region_t       wdata,
  input  logic [AW-1:0] raddr,
  output region_t       rdata
);

  region_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/first_fit_free_list_allocator_unit.sv =====
// First-fit free-list allocator with coalescing.
// Input channel in_valid/in_ready/in_data carries one command beat:
// allocate, free a region, or query the free total. Each command yields
// exactly one result beat on out_valid/out_ready/out_data, which carries
// the allocated address and status plus table statistics.
// The block handles one command at a time. Every step reads one table
// entry through the single registered read port of the region memory.
// A command is a scan to find the entry, then a shift of later entries
// when an entry is inserted or removed. Query scans all table entries once.
// in_ready is high only while the sequencer is idle and the output
// register is empty. A stalled receiver holds the result beat in the
// output register and the next command waits until it is taken.
// Synchronous reset (rst_n low) empties the table and clears the peak
// and lost statistics at once; no clearing pass is needed because only
// entries below the entry count are ever read.
module first_fit_free_list_allocator_unit import ffa_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD    = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_PREV  = 10'b0000001000,
    S_NEXT  = 10'b0000010000,
    S_DEC   = 10'b0000100000,
    S_SDN   = 10'b0001000000,
    S_SUP   = 10'b0010000000,
    S_SWR   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  in_item_t cmd_r;
  logic [NW-1:0] used_r, peak_r, idx_r, pos_r;
  logic [31:0] lcnt_r, lsize_r, acc_r, raddr_r;
  logic stat_r, ov_r;
  out_item_t od_r;
  region_t prev_r;
  logic prev_ok_r;

  // Memory port.
  logic we;
  logic [AW-1:0] wa, ra;
  region_t wd, rd;

  ffa_table #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd)
  );

  // Shared adder used for entry ends and query sums.
  logic [31:0] add_a, add_b, add_y;
  assign add_y = add_a + add_b;

  logic [31:0] cmd_end;
  assign cmd_end = cmd_r.addr + cmd_r.size;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // Read address is the current index by default; the shift steps fetch a neighbor.
  always_comb begin
    ra = idx_r[AW-1:0];
    if (state_r == S_PREV) begin
      ra = AW'(idx_r - NW'(1));
    end else if (state_r == S_NEXT) begin
      ra = AW'(idx_r + NW'(1));
    end
  end

  always_comb begin
    add_a = rd.start;
    add_b = rd.len;
    if (kind_t'(cmd_r.kind) == KIND_QUERY) begin
      add_a = acc_r;
    end
  end

  // Free decision signals, evaluated when the scan stops.
  logic scan_hit, at_end, free_end, free_ins, free_lost;
  logic nxt_match;
  assign at_end   = (idx_r >= used_r);
  assign scan_hit = !at_end && (rd.start > cmd_r.addr);
  assign nxt_match = scan_hit && (cmd_end == rd.start);
  assign free_end = (state_r == S_SCAN) && (kind_t'(cmd_r.kind) == KIND_FREE)
                    && (at_end || scan_hit) && !prev_ok_r && !nxt_match;
  assign free_ins  = free_end && (used_r < NW'(TABLE_DEPTH));
  assign free_lost = free_end && !free_ins;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      peak_r  <= '0;
      lcnt_r  <= '0;
      lsize_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_ready) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r     <= in_data;
            idx_r     <= '0;
            acc_r     <= '0;
            raddr_r   <= '0;
            stat_r    <= 1'b0;
            prev_ok_r <= 1'b0;
          end
        end
        S_RD: ;
        S_SCAN: begin
          // rd holds entry idx_r while idx_r is below the entry count.
          if (!at_end) begin
            if (kind_t'(cmd_r.kind) == KIND_QUERY) begin
              acc_r <= add_y;
              idx_r <= idx_r + NW'(1);
            end else if (kind_t'(cmd_r.kind) == KIND_ALLOC) begin
              if (rd.len >= cmd_r.size) begin
                raddr_r <= rd.start;
              end else begin
                idx_r <= idx_r + NW'(1);
              end
            end else if (kind_t'(cmd_r.kind) == KIND_FREE) begin
              if (!(rd.start > cmd_r.addr)) begin
                prev_r    <= rd;
                prev_ok_r <= (add_y == cmd_r.addr);
                idx_r     <= idx_r + NW'(1);
              end
            end
          end
        end
        S_PREV: ;
        S_NEXT: ;
        S_DEC: begin
          used_r <= used_r - NW'(1);
        end
        S_SDN: begin
          idx_r <= idx_r + NW'(1);
        end
        S_SUP: begin
          idx_r <= idx_r - NW'(1);
        end
        S_SWR: ;
        S_DONE: begin
          ov_r <= 1'b1;
          od_r.result_addr  <= raddr_r;
          od_r.status       <= stat_r;
          od_r.total_free   <= (kind_t'(cmd_r.kind) == KIND_QUERY) ? acc_r : '0;
          od_r.entry_count  <= CntW'(used_r);
          od_r.peak_entries <= CntW'(peak_r);
          od_r.lost_count   <= lcnt_r;
          od_r.lost_size    <= lsize_r;
        end
        default: ;
      endcase
      if (state_r == S_SCAN && kind_t'(cmd_r.kind) == KIND_ALLOC
          && idx_r >= used_r) begin
        stat_r <= 1'b1;
      end
      if (free_end) begin
        if (free_ins) begin
          // Remember the slot and start the upward shift at the end.
          pos_r  <= idx_r;
          idx_r  <= used_r;
          used_r <= used_r + NW'(1);
          if (peak_r < used_r + NW'(1)) peak_r <= used_r + NW'(1);
        end else if (free_lost) begin
          lcnt_r  <= lcnt_r + 32'd1;
          lsize_r <= lsize_r + cmd_r.size;
          stat_r  <= 1'b1;
        end
      end
    end
  end

  // Next state and memory writes.
  always_comb begin
    state_nxt = state_r;
    we = 1'b0;
    wa = idx_r[AW-1:0];
    wd = rd;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) state_nxt = S_RD;
      S_RD: state_nxt = S_SCAN;
      S_SCAN: begin
        unique case (kind_t'(cmd_r.kind))
          KIND_QUERY: state_nxt = at_end ? S_DONE : S_RD;
          KIND_ALLOC: begin
            if (at_end) state_nxt = S_DONE;
            else if (rd.len >= cmd_r.size) begin
              if (rd.len == cmd_r.size) state_nxt = S_DEC;
              else begin
                we = 1'b1;
                wd = '{start: rd.start + cmd_r.size, len: rd.len - cmd_r.size};
                state_nxt = S_DONE;
              end
            end else state_nxt = S_RD;
          end
          KIND_FREE: begin
            if (!at_end && !scan_hit) begin
              state_nxt = S_RD;
            end else if (prev_ok_r) begin
              // Grow the preceding entry; maybe absorb the next.
              we = 1'b1;
              wa = AW'(idx_r - NW'(1));
              wd = '{start: prev_r.start,
                     len: prev_r.len + cmd_r.size + (nxt_match ? rd.len : 32'd0)};
              state_nxt = nxt_match ? S_DEC : S_DONE;
            end else if (nxt_match) begin
              we = 1'b1;
              wd = '{start: cmd_r.addr, len: rd.len + cmd_r.size};
              state_nxt = S_DONE;
            end else if (used_r < NW'(TABLE_DEPTH)) begin
              // Open a slot by shifting entries up from the end.
              state_nxt = (used_r == idx_r) ? S_SWR : S_PREV;
            end else state_nxt = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_PREV: state_nxt = S_SUP;
      S_DEC: state_nxt = (idx_r + NW'(1) < used_r) ? S_NEXT : S_DONE;
      S_NEXT: state_nxt = S_SDN;
      S_SDN: begin
        // rd holds entry idx_r+1; move it down.
        we = 1'b1;
        state_nxt = (idx_r + NW'(2) < used_r + NW'(1)) ? S_NEXT : S_DONE;
        if (idx_r + NW'(2) >= used_r + NW'(1)) state_nxt = S_DONE;
      end
      S_SUP: begin
        // rd holds entry idx_r-1; move it up.
        we = 1'b1;
        state_nxt = (idx_r - NW'(1) == pos_r) ? S_SWR : S_PREV;
      end
      S_SWR: begin
        we = 1'b1;
        wa = pos_r[AW-1:0];
        wd = '{start: cmd_r.addr, len: cmd_r.size};
        state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
